>>> rtl/pit_pkg.sv
package pit_pkg;

    localparam int PIT_MAX_FIELD_WIDTH = 63;

    localparam int VALUE_W = 32;
    localparam int WORK_W  = 40;
    localparam int CNT_W   = 6;

    // input mode codes
    localparam logic [2:0] MODE_SDEC = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_HEXL = 3'd2;
    localparam logic [2:0] MODE_HEXU = 3'd3;
    localparam logic [2:0] MODE_OCT  = 3'd4;
    localparam logic [2:0] MODE_BIN  = 3'd5;

    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_HEX,
        RADIX_OCT,
        RADIX_BIN
    } radix_t;

    typedef struct packed {
        logic   start;
        logic   shift;
        radix_t radix;
    } pit_ctrl_t;

    typedef struct packed {
        logic             ready;
        logic [CNT_W-1:0] ndig;
        logic [3:0]       digit;
    } pit_stat_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
        end else if (upper) begin
            c = CHAR_UPPER_A + {4'd0, d} - 8'd10;
        end else begin
            c = CHAR_LOWER_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

>>> rtl/pit_digits.sv
module pit_digits
    import pit_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  pit_ctrl_t          ctrl,
    input  logic [VALUE_W-1:0] mag,
    output pit_stat_t          stat
);

    typedef enum logic [1:0] {
        DG_IDLE,
        DG_DABBLE,
        DG_STRIP,
        DG_READY
    } dg_state_t;

    dg_state_t          state_reg, state_next;
    radix_t             radix_reg, radix_next;
    logic [WORK_W-1:0]  work_reg, work_next;
    logic [VALUE_W-1:0] src_reg, src_next;
    logic [4:0]         bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]   ndig_reg, ndig_next;

    logic [3:0]        top_digit;
    logic [WORK_W-1:0] work_shifted;
    logic [WORK_W-1:0] work_adj;

    always_comb begin
        case (radix_reg)
            RADIX_DEC, RADIX_HEX: begin
                top_digit    = work_reg[WORK_W-1 -: 4];
                work_shifted = {work_reg[WORK_W-5:0], 4'd0};
            end
            RADIX_OCT: begin
                top_digit    = {1'b0, work_reg[WORK_W-1 -: 3]};
                work_shifted = {work_reg[WORK_W-4:0], 3'd0};
            end
            default: begin
                top_digit    = {3'd0, work_reg[WORK_W-1]};
                work_shifted = {work_reg[WORK_W-2:0], 1'b0};
            end
        endcase
    end

    // shift-add-3: each BCD nibble of 5 or more gets 3 added before the shift
    always_comb begin
        for (int i = 0; i < WORK_W / 4; i++) begin
            if (work_reg[4*i +: 4] >= 4'd5) begin
                work_adj[4*i +: 4] = work_reg[4*i +: 4] + 4'd3;
            end else begin
                work_adj[4*i +: 4] = work_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        radix_next   = radix_reg;
        work_next    = work_reg;
        src_next     = src_reg;
        bit_cnt_next = bit_cnt_reg;
        ndig_next    = ndig_reg;
        if (ctrl.start) begin
            radix_next = ctrl.radix;
            case (ctrl.radix)
                RADIX_DEC: begin
                    work_next    = '0;
                    src_next     = mag;
                    bit_cnt_next = 5'd31;
                    state_next   = DG_DABBLE;
                end
                RADIX_HEX: begin
                    work_next  = {mag, 8'd0};
                    ndig_next  = CNT_W'(8);
                    state_next = DG_STRIP;
                end
                RADIX_OCT: begin
                    work_next  = {1'b0, mag, 7'd0};
                    ndig_next  = CNT_W'(11);
                    state_next = DG_STRIP;
                end
                default: begin
                    work_next  = {mag, 8'd0};
                    ndig_next  = CNT_W'(32);
                    state_next = DG_STRIP;
                end
            endcase
        end else begin
            case (state_reg)
                DG_DABBLE: begin
                    work_next    = {work_adj[WORK_W-2:0], src_reg[VALUE_W-1]};
                    src_next     = {src_reg[VALUE_W-2:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg - 5'd1;
                    if (bit_cnt_reg == 5'd0) begin
                        ndig_next  = CNT_W'(10);
                        state_next = DG_STRIP;
                    end
                end
                DG_STRIP: begin
                    // drop leading zero digits, always keep at least one
                    if (top_digit == 4'd0 && ndig_reg > CNT_W'(1)) begin
                        work_next = work_shifted;
                        ndig_next = ndig_reg - CNT_W'(1);
                    end else begin
                        state_next = DG_READY;
                    end
                end
                DG_READY: begin
                    if (ctrl.shift) begin
                        work_next = work_shifted;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DG_IDLE;
        end else begin
            state_reg <= state_next;
        end
        radix_reg   <= radix_next;
        work_reg    <= work_next;
        src_reg     <= src_next;
        bit_cnt_reg <= bit_cnt_next;
        ndig_reg    <= ndig_next;
    end

    assign stat.ready = (state_reg == DG_READY);
    assign stat.ndig  = ndig_reg;
    assign stat.digit = top_digit;

endmodule

>>> rtl/padded_integer_to_ascii.sv
// Formats one 32-bit number per input transfer as ASCII text, one character per
// output transfer, most significant digit first, tlast on the final character.
// Modes: signed or unsigned decimal, lower or upper hex, octal, binary.
// One number is in flight at a time; s_tready is high only between numbers.
// Decimal numbers first pass through the bit-serial binary-to-BCD converter,
// which takes one source bit a cycle; leading zero digits are then stripped
// one per cycle (at most 9 decimal, 7 hex, 10 octal, 31 binary), and the
// characters (at most 63) leave one per cycle through the output register
// while the output is free (m_tready high or no character held).
module padded_integer_to_ascii
    import pit_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH = PIT_MAX_FIELD_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // value[31:0], field_width[37:32], pad_with_zeros[38]
    input  logic [2:0]  s_tuser,  // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // text_char[7:0]
    output logic        m_tlast   // last_char
);

    localparam logic [CNT_W-1:0] WIDTH_CAP =
        (MAX_FIELD_WIDTH > 63) ? CNT_W'(63) : CNT_W'(MAX_FIELD_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic             neg_reg;
    logic             upper_reg;
    logic             zpad_reg;
    logic [CNT_W-1:0] width_reg;
    logic [CNT_W-1:0] pad_cnt_reg;
    logic [CNT_W-1:0] dig_cnt_reg;
    logic             m_tvalid_reg;
    logic [7:0]       m_tdata_reg;
    logic             m_tlast_reg;

    pit_ctrl_t dg_ctrl;
    pit_stat_t dg_stat;

    logic [VALUE_W-1:0] in_value;
    logic [CNT_W-1:0]   in_width;
    logic [CNT_W-1:0]   in_width_cap;
    logic               in_neg;
    logic [VALUE_W-1:0] in_mag;
    radix_t             in_radix;
    logic               in_take;
    logic               out_free;
    logic [CNT_W-1:0]   width_eff;
    logic [CNT_W-1:0]   pad_calc;
    logic               emit_digit;

    assign in_value     = s_tdata[31:0];
    assign in_width     = s_tdata[37:32];
    assign in_width_cap = (in_width > WIDTH_CAP) ? WIDTH_CAP : in_width;
    assign in_neg       = (s_tuser == MODE_SDEC) && s_tdata[31];
    assign in_mag       = in_neg ? (VALUE_W'(0) - in_value) : in_value;
    assign in_take      = s_tvalid && s_tready;
    assign out_free     = !m_tvalid_reg || m_tready;

    always_comb begin
        case (s_tuser)
            MODE_HEXL, MODE_HEXU: in_radix = RADIX_HEX;
            MODE_OCT:             in_radix = RADIX_OCT;
            MODE_BIN:             in_radix = RADIX_BIN;
            default:              in_radix = RADIX_DEC;
        endcase
    end

    // the sign takes one place of the field
    assign width_eff = (neg_reg && width_reg != '0) ? width_reg - CNT_W'(1) : width_reg;
    assign pad_calc  = (width_eff > dg_stat.ndig) ? width_eff - dg_stat.ndig : '0;

    assign emit_digit = (state_reg == ST_EMIT) && out_free && !neg_reg && (pad_cnt_reg == '0);

    assign dg_ctrl.start = in_take;
    assign dg_ctrl.shift = emit_digit;
    assign dg_ctrl.radix = in_radix;

    pit_digits u_digits (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (dg_ctrl),
        .mag     (in_mag),
        .stat    (dg_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (in_take) begin
                        neg_reg   <= in_neg;
                        upper_reg <= (s_tuser == MODE_HEXU);
                        zpad_reg  <= s_tdata[38];
                        width_reg <= in_width_cap;
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (dg_stat.ready) begin
                        pad_cnt_reg <= pad_calc;
                        dig_cnt_reg <= dg_stat.ndig;
                        state_reg   <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= 1'b0;
                        if (neg_reg) begin
                            m_tdata_reg <= CHAR_MINUS;
                            neg_reg     <= 1'b0;
                        end else if (pad_cnt_reg != '0) begin
                            m_tdata_reg <= zpad_reg ? CHAR_ZERO : CHAR_SPACE;
                            pad_cnt_reg <= pad_cnt_reg - CNT_W'(1);
                        end else begin
                            m_tdata_reg <= digit_char(dg_stat.digit, upper_reg);
                            dig_cnt_reg <= dig_cnt_reg - CNT_W'(1);
                            if (dig_cnt_reg == CNT_W'(1)) begin
                                m_tlast_reg <= 1'b1;
                                state_reg   <= ST_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_digit_unit_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_digit |-> dg_stat.ready)
        else $error("digit requested before conversion finished");

    a_digits_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (dig_cnt_reg != '0))
        else $error("emitting with no digits left");

    a_printable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >= CHAR_SPACE && m_tdata <= 8'h7A))
        else $error("non-printable character on output");

    a_last_is_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata != CHAR_MINUS && m_tdata != CHAR_SPACE))
        else $error("run ended on sign or space");

endmodule
